>>> design/jtik_pkg.sv
// ----------------------------------------------------------------------------
// jtik_pkg: shared types and constants for the ik step block
// item structs, widths of the shared multiplier, polynomial coefficients
// ----------------------------------------------------------------------------
package jtik_pkg;

  localparam int NUM_SEGMENTS = 3;
  localparam int ANGLE_BITS   = 16;
  localparam int NUM_JOINTS   = 2 * NUM_SEGMENTS;
  localparam int JW           = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

  // shared multiplier operand and product widths
  localparam int MW = 33;
  localparam int PW = 2 * MW;

  typedef struct packed {
    logic               opcode;
    logic [2:0]         angle_index;
    logic [15:0]        angle_value;
    logic signed [23:0] target_x;
    logic signed [23:0] target_y;
    logic signed [23:0] target_z;
  } jtik_in_t;

  typedef struct packed {
    logic [15:0]        angle_out_0;
    logic [15:0]        angle_out_1;
    logic [15:0]        angle_out_2;
    logic [15:0]        angle_out_3;
    logic [15:0]        angle_out_4;
    logic [15:0]        angle_out_5;
    logic signed [23:0] tip_x;
    logic signed [23:0] tip_y;
    logic signed [23:0] tip_z;
  } jtik_out_t;

  localparam logic       OPC_STEP = 1'b0;
  localparam logic       OPC_LOAD = 1'b1;

  // quarter-wave sine polynomial, q2.30
  function automatic logic signed [MW-1:0] poly_coef(input logic [2:0] idx);
    logic signed [MW-1:0] c;
    case (idx)
      3'd0: c = 33'sd1686629713;
      3'd1: c = 33'sd693598668;
      3'd2: c = 33'sd85569306;
      3'd3: c = 33'sd5026995;
      3'd4: c = 33'sd172272;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

>>> design/jacobian_transpose_ik_step.sv
// ----------------------------------------------------------------------------
// jacobian_transpose_ik_step: jacobian-transpose inverse kinematics step
// six joint angles of a three-segment arm, one descent step or angle load
// ----------------------------------------------------------------------------
// a load request goes from idle straight to the result stage; a step request runs
//   the trig and rotation micro steps for every joint, then the tip and error, then
//   the gradient updates, which are skipped when the target is zero
// throughput: one request at a time, set by the single shared multiplier
//   (every multiply passes through the multiply and writeback states)
// reset (rst_n low, synchronous): angles zero, gain 2059, no result pending
module jacobian_transpose_ik_step (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  jtik_pkg::jtik_in_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output jtik_pkg::jtik_out_t   out_data,
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_wdata
);
  import jtik_pkg::*;

  // top-level sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_WB   = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  // micro steps, each one pass through the multiply and writeback states
  localparam logic [3:0] OP_K     = 4'd0;   // gain times 1/(2 pi)
  localparam logic [3:0] OP_TX2   = 4'd1;   // x squared
  localparam logic [3:0] OP_TPOLY = 4'd2;   // horner step
  localparam logic [3:0] OP_TFIN  = 4'd3;   // poly times x
  localparam logic [3:0] OP_R0    = 4'd4;   // rotation products
  localparam logic [3:0] OP_R1    = 4'd5;
  localparam logic [3:0] OP_R2    = 4'd6;
  localparam logic [3:0] OP_R3    = 4'd7;
  localparam logic [3:0] OP_REC   = 4'd8;   // record joint axis and position
  localparam logic [3:0] OP_TIP   = 4'd9;   // tip and error
  localparam logic [3:0] OP_LD    = 4'd10;  // load joint axis and lever
  localparam logic [3:0] OP_CA    = 4'd11;  // cross product halves
  localparam logic [3:0] OP_CB    = 4'd12;
  localparam logic [3:0] OP_G     = 4'd13;  // column dot error
  localparam logic [3:0] OP_D     = 4'd14;  // gradient to angle delta

  localparam int RW  = 20;           // rotation entries, q14
  localparam int PNW = 24;           // positions, q14
  localparam int VW  = PNW + 1;      // lever arm
  localparam int CW  = 27;           // jacobian column entries
  localparam int EW  = 26;           // error, q12
  localparam int AW  = PW + 2;       // accumulator
  localparam int DS  = 44 - ANGLE_BITS;
  localparam int SH_L = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
  localparam int SH_R = (ANGLE_BITS >= 16) ? 0 : 16 - ANGLE_BITS;
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic [13:0] INV_TWO_PI_Q16 = 14'd10430;
  localparam logic signed [RW-1:0] ONE_Q14 = RW'(16384);
  localparam logic signed [AW-1:0] HALF_Q14 = AW'(8192);
  localparam logic signed [AW-1:0] G_MAX = AW'(64'sd2147483647);
  localparam logic signed [AW-1:0] G_MIN = -AW'(64'sd2147483648);

  // control
  logic [1:0]             state_r;
  logic [3:0]             op_r;
  logic [JW-1:0]          jn_r;
  logic [1:0]             k_r;
  logic [1:0]             tcnt_r;
  logic                   tsel_r;
  logic                   out_valid_r;
  logic [15:0]            gain_r;

  // datapath
  logic [ANGLE_BITS-1:0]  angle_r [NUM_JOINTS];
  logic signed [RW-1:0]   r_r     [3][3];
  logic signed [PNW-1:0]  p_r     [3];
  logic signed [RW-1:0]   axis_r  [NUM_JOINTS][3];
  logic signed [PNW-1:0]  pos_r   [NUM_JOINTS][3];
  logic signed [RW-1:0]   av_r    [3];
  logic signed [VW-1:0]   rvv_r   [3];
  logic signed [CW-1:0]   col_r   [3];
  logic signed [EW-1:0]   err_r   [3];
  logic signed [23:0]     tgt_r   [3];
  logic signed [23:0]     tip_r   [3];
  logic signed [31:0]     g_r;
  logic [29:0]            kgain_r;
  logic [30:0]            x2_r;
  logic signed [MW-1:0]   poly_r;
  logic signed [15:0]     cos_r;
  logic signed [15:0]     sg_r;
  logic signed [RW-1:0]   tmp_r;
  logic signed [AW-1:0]   acc_r;
  jtik_out_t              out_data_r;

  // combinational
  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [PW-1:0]   prod_w;
  logic signed [AW-1:0]   prod_ext, rsum_w, rdiff_w, gsum_w, delta_w;
  logic signed [PW-1:0]   sh30_w;
  logic signed [PW-1:0]   s0_w;
  logic signed [15:0]     s_w;
  logic [ANGLE_BITS-1:0]  ang_w;
  logic [31:0]            ph_w;
  logic [30:0]            xb_w, x_w;
  logic signed [RW-1:0]   first_w, second_w;
  logic signed [31:0]     gclamp_w;
  logic signed [23:0]     tip_w   [3];
  logic signed [EW-1:0]   err_w   [3];
  logic [39:0]            load_w;
  logic [15:0]            ang16_w [6];
  logic                   tgt_zero_w;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // phase of the angle under the trig sequence, cosine first
  assign ang_w = angle_r[jn_r] + (tsel_r ? '0 : QUARTER);
  assign ph_w  = {ang_w, {(32 - ANGLE_BITS){1'b0}}};
  assign xb_w  = {1'b0, ph_w[29:0]};
  assign x_w   = ph_w[30] ? (31'h4000_0000 - xb_w) : xb_w;

  jtik_mul u_mul (
    .clk    (clk),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_r (prod_w)
  );

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_r)
      OP_K: begin
        mul_a = MW'($signed({1'b0, gain_r}));
        mul_b = MW'($signed({1'b0, INV_TWO_PI_Q16}));
      end
      OP_TX2: begin
        mul_a = MW'($signed({1'b0, x_w}));
        mul_b = MW'($signed({1'b0, x_w}));
      end
      OP_TPOLY: begin
        mul_a = poly_r;
        mul_b = MW'($signed({1'b0, x2_r}));
      end
      OP_TFIN: begin
        mul_a = poly_r;
        mul_b = MW'($signed({1'b0, x_w}));
      end
      OP_R0: begin
        mul_a = MW'(cos_r);
        mul_b = MW'(r_r[0][0]);
      end
      OP_R1: begin
        mul_a = MW'(sg_r);
        mul_b = jn_r[0] ? MW'(r_r[0][2]) : MW'(r_r[0][1]);
      end
      OP_R2: begin
        mul_a = MW'(cos_r);
        mul_b = jn_r[0] ? MW'(r_r[0][2]) : MW'(r_r[0][1]);
      end
      OP_R3: begin
        mul_a = MW'(sg_r);
        mul_b = MW'(r_r[0][0]);
      end
      OP_CA: begin
        mul_a = MW'(av_r[1]);
        mul_b = MW'(rvv_r[2]);
      end
      OP_CB: begin
        mul_a = MW'(av_r[2]);
        mul_b = MW'(rvv_r[1]);
      end
      OP_G: begin
        mul_a = MW'(col_r[0]);
        mul_b = MW'(err_r[0]);
      end
      OP_D: begin
        mul_a = MW'(g_r);
        mul_b = MW'($signed({1'b0, kgain_r}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // writeback arithmetic; the rounded results round half up by add and arithmetic shift
  always_comb begin
    prod_ext = AW'(prod_w);
    rsum_w   = acc_r + prod_ext;
    rdiff_w  = acc_r - prod_ext;
    first_w  = RW'((rsum_w + HALF_Q14) >>> 14);
    second_w = RW'((rdiff_w + HALF_Q14) >>> 14);
    sh30_w   = prod_w >>> 30;
    s0_w     = (sh30_w + PW'(32768)) >>> 16;
    // clamp sine magnitude to one, then apply the half-wave sign
    if (s0_w > PW'(16384)) s_w = 16'sd16384;
    else                   s_w = 16'(s0_w);
    if (ph_w[31]) s_w = -s_w;
    gsum_w = (rsum_w + HALF_Q14) >>> 14;
    if (gsum_w > G_MAX)      gclamp_w = 32'sh7fff_ffff;
    else if (gsum_w < G_MIN) gclamp_w = 32'sh8000_0000;
    else                     gclamp_w = 32'(gsum_w);
    delta_w = (prod_ext + (AW'(1) <<< (DS - 1))) >>> DS;
    tgt_zero_w = 1'b1;
    for (int k = 0; k < 3; k++) begin
      tip_w[k] = 24'((25'(p_r[k]) + 25'sd2) >>> 2);
      err_w[k] = EW'(tgt_r[k]) - EW'(tip_w[k]);
      if (tgt_r[k] != '0) tgt_zero_w = 1'b0;
    end
    load_w = ({24'b0, in_data.angle_value} << SH_L) >> SH_R;
    for (int j = 0; j < 6; j++) begin
      ang16_w[j] = '0;
      if (j < NUM_JOINTS)
        ang16_w[j] = 16'(({24'b0, angle_r[j]} << SH_R) >> SH_L);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_K;
      jn_r        <= '0;
      k_r         <= '0;
      tcnt_r      <= '0;
      tsel_r      <= 1'b0;
      out_valid_r <= 1'b0;
      gain_r      <= 16'd2059;
      for (int j = 0; j < NUM_JOINTS; j++) angle_r[j] <= '0;
    end else begin
      if (cfg_we) gain_r <= cfg_wdata;
      // result register: loaded from the result stage, cleared when taken
      if (state_r == ST_OUT && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready)                    out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_data.opcode == OPC_LOAD) begin
              if ({1'b0, in_data.angle_index} < 4'(NUM_JOINTS))
                angle_r[in_data.angle_index[JW-1:0]] <= load_w[ANGLE_BITS-1:0];
              for (int k = 0; k < 3; k++) tip_r[k] <= '0;
              state_r <= ST_OUT;
            end else begin
              // identity frame at the base, tip at origin
              for (int a = 0; a < 3; a++) begin
                p_r[a] <= '0;
                for (int b = 0; b < 3; b++) r_r[a][b] <= (a == b) ? ONE_Q14 : '0;
              end
              tgt_r[0] <= in_data.target_x;
              tgt_r[1] <= in_data.target_y;
              tgt_r[2] <= in_data.target_z;
              jn_r    <= '0;
              tsel_r  <= 1'b0;
              op_r    <= OP_K;
              state_r <= ST_MUL;
            end
          end
        end

        ST_MUL: state_r <= ST_WB;

        ST_WB: begin
          // zero target only reports the tip; last joint update ends the step
          if (op_r > OP_D)
            state_r <= ST_IDLE;
          else if ((op_r == OP_TIP && tgt_zero_w) ||
                   (op_r == OP_D && jn_r == JW'(NUM_JOINTS - 1)))
            state_r <= ST_OUT;
          else
            state_r <= ST_MUL;
          case (op_r)
            OP_K: begin
              kgain_r <= prod_w[29:0];
              op_r    <= OP_TX2;
            end
            OP_TX2: begin
              x2_r   <= sh30_w[30:0];
              poly_r <= poly_coef(3'd4);
              tcnt_r <= 2'd3;
              op_r   <= OP_TPOLY;
            end
            OP_TPOLY: begin
              poly_r <= poly_coef({1'b0, tcnt_r}) - MW'(sh30_w);
              if (tcnt_r == 2'd0) op_r <= OP_TFIN;
              else                tcnt_r <= tcnt_r - 2'd1;
            end
            OP_TFIN: begin
              if (!tsel_r) begin
                cos_r  <= s_w;
                tsel_r <= 1'b1;
                op_r   <= OP_TX2;
              end else begin
                // y joints turn the other way in the x-z plane
                sg_r <= jn_r[0] ? -s_w : s_w;
                k_r  <= '0;
                op_r <= OP_R0;
              end
            end
            OP_R0: begin
              acc_r <= prod_ext;
              op_r  <= OP_R1;
            end
            OP_R1: begin
              tmp_r <= first_w;
              op_r  <= OP_R2;
            end
            OP_R2: begin
              acc_r <= prod_ext;
              op_r  <= OP_R3;
            end
            OP_R3: begin
              // rows rotate through the head slot
              r_r[0] <= r_r[1];
              r_r[1] <= r_r[2];
              r_r[2][0] <= tmp_r;
              r_r[2][1] <= jn_r[0] ? r_r[0][1] : second_w;
              r_r[2][2] <= jn_r[0] ? second_w  : r_r[0][2];
              if (k_r == 2'd2) op_r <= OP_REC;
              else begin
                k_r  <= k_r + 2'd1;
                op_r <= OP_R0;
              end
            end
            OP_REC: begin
              for (int k = 0; k < 3; k++) begin
                axis_r[jn_r][k] <= jn_r[0] ? r_r[k][1] : r_r[k][2];
                pos_r[jn_r][k]  <= p_r[k];
                if (jn_r[0]) p_r[k] <= p_r[k] + PNW'(r_r[k][2]);
              end
              if (jn_r == JW'(NUM_JOINTS - 1)) op_r <= OP_TIP;
              else begin
                jn_r   <= jn_r + JW'(1);
                tsel_r <= 1'b0;
                op_r   <= OP_TX2;
              end
            end
            OP_TIP: begin
              for (int k = 0; k < 3; k++) begin
                tip_r[k] <= tip_w[k];
                err_r[k] <= err_w[k];
              end
              jn_r <= '0;
              op_r <= OP_LD;
            end
            OP_LD: begin
              for (int k = 0; k < 3; k++) begin
                av_r[k]  <= axis_r[jn_r][k];
                rvv_r[k] <= VW'(p_r[k]) - VW'(pos_r[jn_r][k]);
              end
              k_r  <= '0;
              op_r <= OP_CA;
            end
            OP_CA: begin
              acc_r <= prod_ext;
              op_r  <= OP_CB;
            end
            OP_CB: begin
              col_r[0] <= col_r[1];
              col_r[1] <= col_r[2];
              col_r[2] <= CW'((rdiff_w + HALF_Q14) >>> 14);
              av_r[0]  <= av_r[1];
              av_r[1]  <= av_r[2];
              av_r[2]  <= av_r[0];
              rvv_r[0] <= rvv_r[1];
              rvv_r[1] <= rvv_r[2];
              rvv_r[2] <= rvv_r[0];
              if (k_r == 2'd2) begin
                k_r  <= '0;
                op_r <= OP_G;
              end else begin
                k_r  <= k_r + 2'd1;
                op_r <= OP_CA;
              end
            end
            OP_G: begin
              acc_r    <= (k_r == 2'd0) ? prod_ext : rsum_w;
              col_r[0] <= col_r[1];
              col_r[1] <= col_r[2];
              col_r[2] <= col_r[0];
              err_r[0] <= err_r[1];
              err_r[1] <= err_r[2];
              err_r[2] <= err_r[0];
              if (k_r == 2'd2) begin
                g_r  <= gclamp_w;
                op_r <= OP_D;
              end else begin
                k_r <= k_r + 2'd1;
              end
            end
            OP_D: begin
              angle_r[jn_r] <= angle_r[jn_r] + delta_w[ANGLE_BITS-1:0];
              if (jn_r != JW'(NUM_JOINTS - 1)) begin
                jn_r <= jn_r + JW'(1);
                op_r <= OP_LD;
              end
            end
            default: op_r <= OP_K;
          endcase
        end

        ST_OUT: begin
          // hold until the result register is free
          if (!out_valid_r || out_ready) begin
            out_data_r.angle_out_0 <= ang16_w[0];
            out_data_r.angle_out_1 <= ang16_w[1];
            out_data_r.angle_out_2 <= ang16_w[2];
            out_data_r.angle_out_3 <= ang16_w[3];
            out_data_r.angle_out_4 <= ang16_w[4];
            out_data_r.angle_out_5 <= ang16_w[5];
            out_data_r.tip_x       <= tip_r[0];
            out_data_r.tip_y       <= tip_r[1];
            out_data_r.tip_z       <= tip_r[2];
            state_r                <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // every writeback follows a multiply cycle
  a_wb_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WB |-> $past(state_r) == ST_MUL)
    else $error("writeback without multiply");

  // a load request goes straight to the result stage
  a_load_direct: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.opcode == OPC_LOAD |=> state_r == ST_OUT)
    else $error("load did not complete directly");

  // a new result is only produced from the result stage
  a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("result raised outside result stage");

  // joint counter stays in range during the update
  a_jn_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WB && op_r == OP_D |-> {1'b0, jn_r} < (JW + 1)'(NUM_JOINTS))
    else $error("joint index out of range");

endmodule

>>> design/jtik_mul.sv
// ----------------------------------------------------------------------------
// jtik_mul: shared signed multiplier
// one registered signed product per cycle, used for every multiply of the ik step
// ----------------------------------------------------------------------------
module jtik_mul (
  input  logic                              clk,
  input  logic signed [jtik_pkg::MW-1:0]    a_i,
  input  logic signed [jtik_pkg::MW-1:0]    b_i,
  output logic signed [jtik_pkg::PW-1:0]    prod_r
);
  import jtik_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= a_i * b_i;
  end

endmodule

>>> tb/jacobian_transpose_ik_step_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jacobian_transpose_ik_step_checker: result checker for the ik step block
// watches the request, result and gain ports, models the arm and compares
// every result field by field against the oldest prediction
// ----------------------------------------------------------------------------
module jacobian_transpose_ik_step_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  jtik_pkg::jtik_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  jtik_pkg::jtik_out_t out_data,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  output int                  pending,
  output int                  failures
);
  import jtik_pkg::*;

  localparam longint HALF_TURN_Q30 = 64'sd1073741824;
  localparam longint TURN_RATE_Q16 = 64'sd10430;
  localparam longint GRAD_MAX      = 64'sd2147483647;
  localparam longint TIP_HI        = 64'sd8388607;
  localparam longint TIP_LO        = -64'sd8388608;

  longint    sine_coef [5] = '{64'sd1686629713, 64'sd693598668, 64'sd85569306,
                               64'sd5026995, 64'sd172272};
  logic [15:0] arm_angle [6];
  logic [15:0] gain_q16;
  jtik_out_t   pose_queue [$];

  assign pending = pose_queue.size();

  function automatic longint rnd_shift(longint v, int k);
    return (v + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  function automatic longint sine_q14(logic [15:0] a);
    logic [31:0] ph;
    longint      x, x2, p, s;
    ph = {a, 16'h0000};
    x  = longint'(ph[29:0]);
    if (ph[30]) x = HALF_TURN_Q30 - x;
    x2 = (x * x) >>> 30;
    p  = sine_coef[4];
    for (int i = 3; i >= 0; i--) p = sine_coef[i] - ((p * x2) >>> 30);
    s = (p * x) >>> 30;
    s = (s + 32768) >>> 16;
    if (s > 16384) s = 16384;
    return ph[31] ? -s : s;
  endfunction

  function automatic longint cosine_q14(logic [15:0] a);
    return sine_q14(a + 16'd16384);
  endfunction

  function automatic longint sat_tip(longint v);
    return v < TIP_LO ? TIP_LO : (v > TIP_HI ? TIP_HI : v);
  endfunction

  // forward kinematics plus one transpose descent step unless the target is zero, or a load
  function automatic jtik_out_t solve_pose(jtik_in_t req);
    jtik_out_t res;
    longint    rot [3][3];
    longint    p [3], tip [3], err [3], rv [3], col [3];
    longint    axis [6][3], jpos [6][3];
    longint    c, s, a, b, g, delta;
    logic      moving;
    for (int k = 0; k < 3; k++) begin
      tip[k] = 0;
      p[k] = 0;
      for (int m = 0; m < 3; m++) rot[k][m] = (k == m) ? 16384 : 0;
    end
    if (req.opcode == OPC_LOAD) begin
      if (req.angle_index < NUM_JOINTS) arm_angle[req.angle_index] = req.angle_value;
    end else begin
      for (int i = 0; i < NUM_SEGMENTS; i++) begin
        c = cosine_q14(arm_angle[2*i]);
        s = sine_q14(arm_angle[2*i]);
        for (int k = 0; k < 3; k++) begin
          a = rot[k][0];
          b = rot[k][1];
          rot[k][0] = rnd_shift(c * a + s * b, 14);
          rot[k][1] = rnd_shift(c * b - s * a, 14);
        end
        for (int k = 0; k < 3; k++) begin
          axis[2*i][k] = rot[k][2];
          jpos[2*i][k] = p[k];
        end
        c = cosine_q14(arm_angle[2*i+1]);
        s = sine_q14(arm_angle[2*i+1]);
        for (int k = 0; k < 3; k++) begin
          a = rot[k][0];
          b = rot[k][2];
          rot[k][0] = rnd_shift(c * a - s * b, 14);
          rot[k][2] = rnd_shift(s * a + c * b, 14);
        end
        for (int k = 0; k < 3; k++) begin
          axis[2*i+1][k] = rot[k][1];
          jpos[2*i+1][k] = p[k];
        end
        for (int k = 0; k < 3; k++) p[k] += rot[k][2];
      end
      tip[0] = rnd_shift(p[0], 2);
      tip[1] = rnd_shift(p[1], 2);
      tip[2] = rnd_shift(p[2], 2);
      err[0] = longint'(req.target_x) - tip[0];
      err[1] = longint'(req.target_y) - tip[1];
      err[2] = longint'(req.target_z) - tip[2];
      moving = (req.target_x != 0) || (req.target_y != 0) || (req.target_z != 0);
      if (moving) begin
        for (int j = 0; j < NUM_JOINTS; j++) begin
          for (int k = 0; k < 3; k++) rv[k] = p[k] - jpos[j][k];
          col[0] = rnd_shift(axis[j][1] * rv[2] - axis[j][2] * rv[1], 14);
          col[1] = rnd_shift(axis[j][2] * rv[0] - axis[j][0] * rv[2], 14);
          col[2] = rnd_shift(axis[j][0] * rv[1] - axis[j][1] * rv[0], 14);
          g = rnd_shift(col[0] * err[0] + col[1] * err[1] + col[2] * err[2], 14);
          if (g > GRAD_MAX) g = GRAD_MAX;
          if (g < -GRAD_MAX - 1) g = -GRAD_MAX - 1;
          delta = rnd_shift(longint'(gain_q16) * g * TURN_RATE_Q16, 44 - ANGLE_BITS);
          arm_angle[j] = arm_angle[j] + delta[15:0];
        end
      end
    end
    res.angle_out_0 = arm_angle[0];
    res.angle_out_1 = arm_angle[1];
    res.angle_out_2 = arm_angle[2];
    res.angle_out_3 = arm_angle[3];
    res.angle_out_4 = arm_angle[4];
    res.angle_out_5 = arm_angle[5];
    res.tip_x = sat_tip(tip[0]);
    res.tip_y = sat_tip(tip[1]);
    res.tip_z = sat_tip(tip[2]);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    failures++;
  endtask

  initial begin
    failures = 0;
    gain_q16 = 16'd2059;
    foreach (arm_angle[i]) arm_angle[i] = '0;
  end

  always @(posedge clk) begin
    jtik_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pose_queue.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = pose_queue.pop_front();
          if (out_data.angle_out_0 !== want.angle_out_0)
            report_mismatch("angle_out_0", out_data.angle_out_0, want.angle_out_0);
          if (out_data.angle_out_1 !== want.angle_out_1)
            report_mismatch("angle_out_1", out_data.angle_out_1, want.angle_out_1);
          if (out_data.angle_out_2 !== want.angle_out_2)
            report_mismatch("angle_out_2", out_data.angle_out_2, want.angle_out_2);
          if (out_data.angle_out_3 !== want.angle_out_3)
            report_mismatch("angle_out_3", out_data.angle_out_3, want.angle_out_3);
          if (out_data.angle_out_4 !== want.angle_out_4)
            report_mismatch("angle_out_4", out_data.angle_out_4, want.angle_out_4);
          if (out_data.angle_out_5 !== want.angle_out_5)
            report_mismatch("angle_out_5", out_data.angle_out_5, want.angle_out_5);
          if (out_data.tip_x !== want.tip_x)
            report_mismatch("tip_x", out_data.tip_x, want.tip_x);
          if (out_data.tip_y !== want.tip_y)
            report_mismatch("tip_y", out_data.tip_y, want.tip_y);
          if (out_data.tip_z !== want.tip_z)
            report_mismatch("tip_z", out_data.tip_z, want.tip_z);
        end
      end
      if (in_valid && in_ready) pose_queue.push_back(solve_pose(in_data));
      if (cfg_we) gain_q16 = cfg_wdata;
    end
  end

endmodule

>>> tb/jacobian_transpose_ik_step_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jacobian_transpose_ik_step_test: top of the ik step testbench
// drives directed and random load and step requests with random gaps and
// back pressure, sweeps the gain between phases, and gives the verdict
// ----------------------------------------------------------------------------
module jacobian_transpose_ik_step_test;
  import jtik_pkg::*;

  localparam int RANDOM_REQUESTS = 1830;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  jtik_in_t    in_data;
  logic        out_valid;
  logic        out_ready;
  jtik_out_t   out_data;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          pending;
  int          failures;

  // stimulus knobs read by the driver processes
  logic        gaps_on;
  int          hold_cycles;
  logic        hold_req;

  jacobian_transpose_ik_step DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  jacobian_transpose_ik_step_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pending   (pending),
    .failures  (failures)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // result side: random stalls, plus one long hold-off counted here
  always @(negedge clk) begin
    if (hold_req && hold_cycles == 0) begin
      hold_cycles <= 1500;
      out_ready   <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready   <= 1'b0;
    end else if (!gaps_on) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 14);
    end
  end

  // one request; called at a falling edge, returns at a falling edge
  task automatic send_request(jtik_in_t req);
    if (gaps_on && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic jtik_in_t make_load(logic [2:0] idx, logic [15:0] val);
    jtik_in_t req;
    req             = jtik_in_t'({$urandom, $urandom, $urandom});
    req.opcode      = OPC_LOAD;
    req.angle_index = idx;
    req.angle_value = val;
    return req;
  endfunction

  function automatic jtik_in_t make_step(logic signed [23:0] tx, logic signed [23:0] ty,
                                         logic signed [23:0] tz);
    jtik_in_t req;
    req             = jtik_in_t'({$urandom, $urandom, $urandom});
    req.opcode      = OPC_STEP;
    req.target_x    = tx;
    req.target_y    = ty;
    req.target_z    = tz;
    return req;
  endfunction

  // target coordinate: mostly within +/-16384, sometimes anywhere, sometimes zero
  function automatic logic signed [23:0] pick_coord();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return 24'($signed($urandom_range(0, 32767)) - 16384);
    if (sel < 95) return 24'($urandom);
    return '0;
  endfunction

  function automatic jtik_in_t random_request();
    int sel;
    sel = $urandom_range(99);
    if (sel < 35) return make_load(3'($urandom_range(0, 5)), 16'($urandom));
    if (sel < 40) return make_load(3'($urandom_range(6, 7)), 16'($urandom));
    if (sel < 45) return make_step('0, '0, '0);
    return make_step(pick_coord(), pick_coord(), pick_coord());
  endfunction

  // gain write only with nothing in flight
  task automatic write_gain(logic [15:0] g);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_wdata <= g;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [15:0] gain_plan [6];
    int          per_phase;
    gain_plan = '{16'd0, 16'd65535, 16'd1, 16'd2059, 16'd0, 16'd0};
    gain_plan[4] = 16'($urandom);
    gain_plan[5] = 16'($urandom_range(1000, 8000));
    per_phase    = RANDOM_REQUESTS / 6;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    out_ready   = 1'b0;
    gaps_on     = 1'b1;
    hold_req    = 1'b0;
    hold_cycles = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset pose, zero target, far targets, loads at the extremes
    send_request(make_step(24'sd4096, 24'sd0, 24'sd0));
    send_request(make_step('0, '0, '0));
    send_request(make_step(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF));
    send_request(make_step(24'sh800000, 24'sh800000, 24'sh800000));
    send_request(make_load(3'd0, 16'hFFFF));
    send_request(make_load(3'd1, 16'h4000));
    send_request(make_load(3'd2, 16'h8000));
    send_request(make_load(3'd3, 16'hC000));
    send_request(make_load(3'd4, 16'h0000));
    send_request(make_load(3'd5, 16'h2000));
    send_request(make_load(3'd6, 16'h1234));
    send_request(make_load(3'd7, 16'hFFFF));
    send_request(make_step('0, '0, '0));
    send_request(make_step(24'sd8192, -24'sd4096, 24'sd2048));
    send_request(make_step(24'sh800000, 24'sh7FFFFF, 24'sd0));
    write_gain(16'd65535);
    send_request(make_step(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF));
    send_request(make_step(-24'sd12288, 24'sd0, 24'sd1));

    // random phases, one gain setting each
    for (int ph = 0; ph < 6; ph++) begin
      write_gain(gain_plan[ph]);
      gaps_on = (ph != 2);
      for (int n = 0; n < per_phase; n++) begin
        if (ph == 3 && n == 20) hold_req <= 1'b1;
        if (ph == 3 && n == 21) hold_req <= 1'b0;
        send_request(random_request());
      end
    end
    in_valid <= 1'b0;
    gaps_on = 1'b1;

    while (pending != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (failures == 0)
      $display("jacobian_transpose_ik_step test passed");
    else
      $display("jacobian_transpose_ik_step test failed");
    $finish;
  end

  // run limit
  initial begin
    #8000000;
    $display("jacobian_transpose_ik_step test failed");
    $finish;
  end

endmodule

>>> filelist.f
design/jtik_pkg.sv
design/jtik_mul.sv
design/jacobian_transpose_ik_step.sv
tb/jacobian_transpose_ik_step_checker.sv
tb/jacobian_transpose_ik_step_test.sv
